@@ src/spq_pkg.sv @@
package spq_pkg;

  localparam int IdW   = 8;
  localparam int PrioW = 4;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } spq_op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_POPPED    = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_DROP_FULL = 2'd3
  } spq_status_t;

  typedef struct packed {
    logic [IdW-1:0]   task_id;
    logic [PrioW-1:0] prio;
  } spq_entry_t;

endpackage

@@ src/spq_if.sv @@
interface spq_in_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  spq_op_t             op;
  logic [IdW-1:0]      task_id;
  logic [PrioW-1:0]    priority_req;

  modport source (output valid, op, task_id, priority_req, input ready);
  modport sink   (input valid, op, task_id, priority_req, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
  logic                valid;
  logic                ready;
  logic [IdW-1:0]      out_task_id;
  logic [PrioW-1:0]    out_priority;
  spq_status_t         status;
  logic [4:0]          entry_count;
  logic                not_empty;

  modport source (output valid, out_task_id, out_priority, status, entry_count, not_empty,
                  input ready);
  modport sink   (input valid, out_task_id, out_priority, status, entry_count, not_empty,
                  output ready);
endinterface

@@ src/stable_priority_queue.sv @@
// Sequence: a pop reads the head slot, stages the entry, then loads the output register;
//   an insert moves each stored entry of lower priority than the new task one slot back
//   (one read/write step each) from the tail, then writes the new task; full/empty is staged directly.
// Throughput: one transaction at a time; the next is taken once the result is registered,
//   which waits for the output to be free. The scan goes one slot per cycle, tail to head.
// Reset (synchronous, rst_n low): queue empty, head at slot 0, no result pending.
//   Memory contents are not cleared; slots are only read below the count.
module stable_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,    // read data for the current slot is on rd_q
    S_WR,    // scan reached the head, or queue was empty: drop the new task in
    S_EMIT   // result staged, waiting for the output register
  } state_t;

  // Circular buffer: slot offset 0 is the head, entries sorted by priority (stable).
  spq_entry_t mem [DEPTH];
  spq_entry_t rd_q;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;     // offset of the hole being filled
  spq_op_t         op_r, op_nxt;
  spq_entry_t      new_r, new_nxt;     // task being inserted

  // staged result
  spq_entry_t      res_ent_r, res_ent_nxt;
  spq_status_t     res_st_r, res_st_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  spq_entry_t      out_ent_r, out_ent_nxt;
  spq_status_t     out_st_r, out_st_nxt;
  logic [CW-1:0]   out_cnt_r, out_cnt_nxt;

  // memory port controls
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  spq_entry_t      wr_data;

  logic [CW+4:0]   cnt_ext;

  // head + offset, wrapped at DEPTH (sum stays below 2*DEPTH)
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] off);
    logic [AW+CW:0] sum;
    sum = (AW+CW+1)'(head) + (AW+CW+1)'(off);
    if (sum >= (AW+CW+1)'(DEPTH)) begin
      sum = sum - (AW+CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign in_chan.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    op_nxt        = op_r;
    new_nxt       = new_r;
    res_ent_nxt   = res_ent_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_ent_nxt   = out_ent_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    wr_data       = new_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt      = in_chan.op;
          new_nxt     = '{task_id: in_chan.task_id, prio: in_chan.priority_req};
          res_ent_nxt = '0;
          if (in_chan.op == OP_INSERT) begin
            if (count_r == CW'(DEPTH)) begin
              res_st_nxt = ST_DROP_FULL;
              state_nxt  = S_EMIT;
            end else if (count_r == '0) begin
              state_nxt = S_WR;
            end else begin
              // start at the tail: look at the last stored entry
              pos_nxt   = count_r;
              rd_en     = 1'b1;
              rd_addr   = phys(head_r, count_r - CW'(1));
              state_nxt = S_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = ST_POP_EMPTY;
              state_nxt  = S_EMIT;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              state_nxt = S_RD;
            end
          end
        end
      end

      S_RD: begin
        if (op_r == OP_POP) begin
          res_ent_nxt = rd_q;
          res_st_nxt  = ST_POPPED;
          head_nxt    = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          count_nxt   = count_r - CW'(1);
          state_nxt   = S_EMIT;
        end else if (rd_q.prio < new_r.prio) begin
          // lower priority moves one slot back, hole moves forward
          wr_en   = 1'b1;
          wr_addr = phys(head_r, pos_r);
          wr_data = rd_q;
          pos_nxt = pos_r - CW'(1);
          if (pos_nxt == '0) begin
            state_nxt = S_WR;
          end else begin
            rd_en   = 1'b1;
            rd_addr = phys(head_r, pos_nxt - CW'(1));
          end
        end else begin
          // equal or higher priority ahead: new task goes right behind it
          wr_en      = 1'b1;
          wr_addr    = phys(head_r, pos_r);
          wr_data    = new_r;
          count_nxt  = count_r + CW'(1);
          res_st_nxt = ST_INSERTED;
          state_nxt  = S_EMIT;
        end
      end

      S_WR: begin
        wr_en      = 1'b1;
        wr_addr    = head_r;
        wr_data    = new_r;
        count_nxt  = count_r + CW'(1);
        res_st_nxt = ST_INSERTED;
        state_nxt  = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = res_ent_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r     <= pos_nxt;
    op_r      <= op_nxt;
    new_r     <= new_nxt;
    res_ent_r <= res_ent_nxt;
    res_st_r  <= res_st_nxt;
    out_ent_r <= out_ent_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign cnt_ext = (CW+5)'(out_cnt_r);

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_task_id  = out_ent_r.task_id;
  assign out_chan.out_priority = out_ent_r.prio;
  assign out_chan.status       = out_st_r;
  assign out_chan.entry_count  = cnt_ext[4:0];
  assign out_chan.not_empty    = (out_cnt_r != '0);

endmodule
